@@ src/best_box_match_select_top_macros.svh @@
`ifndef BEST_BOX_MATCH_SELECT_TOP_MACROS_SVH
`define BEST_BOX_MATCH_SELECT_TOP_MACROS_SVH

// clocked assertion, off while reset is high
`define BBMS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bbms assertion failed");

// clocked assertion, checked through reset as well
`define BBMS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bbms assertion failed");

`endif

@@ src/bbms_pkg.sv @@
`default_nettype none

package bbms_pkg;

  localparam int COORD_W  = 12;
  localparam int FIELD_W  = 12;
  localparam int MAX_CAND = 256;
  localparam int CNT_W    = $clog2(MAX_CAND);
  localparam int INDEX_W  = 8;
  localparam int COST_W   = 19;
  localparam int AREA_W   = 25;

  localparam logic [COST_W-1:0] COST_MAX     = '1;
  localparam logic [COST_W-1:0] MAX_COST_RST = COST_W'(1600);

  // sum of two squares, then scaled by 256 for Q4
  localparam int SQ_W   = 2 * COORD_W + 1;
  localparam int RAD_W  = SQ_W + 8;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int RADP_W = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 1;
  localparam int STEP_W = $clog2(ROOT_W);
  localparam int SUM_W  = ROOT_W + 1;
  localparam int CMP_W  = (SUM_W > COST_W) ? SUM_W : COST_W;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 56;

  // input tdata offsets
  localparam int OFS_RTOP  = 0;
  localparam int OFS_RLEFT = 12;
  localparam int OFS_RBOT  = 24;
  localparam int OFS_RRGT  = 36;
  localparam int OFS_CTOP  = 48;
  localparam int OFS_CLEFT = 60;
  localparam int OFS_CBOT  = 72;
  localparam int OFS_CRGT  = 84;
  localparam int OFS_AREA  = 96;

  // output tdata offsets
  localparam int OFS_BINDEX = 0;
  localparam int OFS_BCOST  = 8;
  localparam int OFS_BAREA  = 27;

  typedef struct packed {
    logic              fire;
    logic              valid;
    logic              last;
    logic [COST_W-1:0] cost;
    logic [AREA_W-1:0] area;
  } eval_t;

  function automatic logic [COORD_W-1:0] coord_mask(input logic [FIELD_W-1:0] v);
    return COORD_W'(v);
  endfunction

endpackage

`default_nettype wire

@@ src/bbms_isqrt.sv @@
`default_nettype none

// truncating square root, one result bit per cycle
module bbms_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [bbms_pkg::RADP_W-1:0] radicand,
  output logic                            done,
  output logic [bbms_pkg::ROOT_W-1:0]     root
);

  logic                          busy;
  logic [bbms_pkg::STEP_W-1:0]   cnt;
  logic [bbms_pkg::RADP_W-1:0]   rad;
  logic [bbms_pkg::REM_W-1:0]    rem;
  logic [bbms_pkg::ROOT_W+2:0]   rem_sh;
  logic [bbms_pkg::ROOT_W+2:0]   trial;
  logic [bbms_pkg::ROOT_W+2:0]   diff;
  logic                          ge;

  always_comb begin
    rem_sh = {rem, rad[bbms_pkg::RADP_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= bbms_pkg::STEP_W'(bbms_pkg::ROOT_W - 1);
    end else if (busy) begin
      rad  <= {rad[bbms_pkg::RADP_W-3:0], 2'b00};
      rem  <= ge ? diff[bbms_pkg::REM_W-1:0] : rem_sh[bbms_pkg::REM_W-1:0];
      root <= {root[bbms_pkg::ROOT_W-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ src/bbms_select.sv @@
`default_nettype none

// run state, keep/replace decision and result register
module bbms_select (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bbms_pkg::eval_t               eval,
  input  wire logic [bbms_pkg::COST_W-1:0]   max_cost,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [bbms_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                               out_found
);

  logic                          have_best;
  logic [bbms_pkg::COST_W-1:0]   held_cost;
  logic [bbms_pkg::AREA_W-1:0]   held_area;
  logic [bbms_pkg::CNT_W-1:0]    held_index;
  logic [bbms_pkg::CNT_W-1:0]    cand_count;

  logic                          take;
  logic                          have_next;
  logic [bbms_pkg::COST_W-1:0]   cost_next;
  logic [bbms_pkg::AREA_W-1:0]   area_next;
  logic [bbms_pkg::CNT_W-1:0]    index_next;
  logic [bbms_pkg::OUT_DATA_W-1:0] out_data_next;

  always_comb begin
    take = eval.valid && (!have_best ||
           (eval.cost < max_cost && eval.cost < held_cost && eval.area > held_area));
    have_next  = have_best || take;
    cost_next  = take ? eval.cost  : held_cost;
    area_next  = take ? eval.area  : held_area;
    index_next = take ? cand_count : held_index;
  end

  // zeros when nothing was found, since the held fields stay cleared then
  always_comb begin
    out_data_next = '0;
    out_data_next[bbms_pkg::OFS_BINDEX +: bbms_pkg::INDEX_W] = bbms_pkg::INDEX_W'(index_next);
    out_data_next[bbms_pkg::OFS_BCOST  +: bbms_pkg::COST_W]  = cost_next;
    out_data_next[bbms_pkg::OFS_BAREA  +: bbms_pkg::AREA_W]  = area_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best  <= 1'b0;
      held_cost  <= '0;
      held_area  <= '0;
      held_index <= '0;
      cand_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (eval.fire && eval.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (eval.fire) begin
        if (eval.last) begin
          have_best  <= 1'b0;
          held_cost  <= '0;
          held_area  <= '0;
          held_index <= '0;
          cand_count <= '0;
        end else begin
          have_best  <= have_next;
          held_cost  <= cost_next;
          held_area  <= area_next;
          held_index <= index_next;
          if (cand_count < bbms_pkg::CNT_W'(bbms_pkg::MAX_CAND - 1)) begin
            cand_count <= cand_count + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval.fire && eval.last) begin
      out_data  <= out_data_next;
      out_found <= have_next;
    end
  end

endmodule

`default_nettype wire

@@ src/best_box_match_select_top.sv @@
// channel   dir  tdata fields (low bit up)                          tuser       tlast
// s_axis    in   region top/left/bottom/right, cand top/left/        cand_valid  last_cand
//                bottom/right (12b each), cand_area (25b), pad to 128
// m_axis    out  best_index (8b), best_cost (19b), best_area (25b)   found       -
//                pad to 56
// cfg       in   cfg_wdata = max_cost (19b), written when cfg_we
//
// Candidates are taken one at a time: the shared 12x12 squarer handles the four coordinate
// pairs, then two square roots run on the shared bit-serial root unit (one root bit a cycle),
// then the decision state and the return to idle. s_axis_tready is high only in idle.
// A result waits in the output register; the next run's last candidate holds in the
// decision cycle until that register is free. rst is synchronous, active high.
`default_nettype none

module best_box_match_select_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // region_top, region_left, region_bottom, region_right, cand_top, cand_left,
  // cand_bottom, cand_right, cand_area
  input  wire logic [bbms_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // cand_valid
  input  wire logic                               s_axis_tuser,
  input  wire logic                               s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // best_index, best_cost, best_area
  output logic [bbms_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // found
  output logic                                    m_axis_tuser,
  input  wire logic                               cfg_we,
  input  wire logic [bbms_pkg::COST_W-1:0]        cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_LAUNCH = 5'b00100,
    ST_ROOT   = 5'b01000,
    ST_DECIDE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [bbms_pkg::COST_W-1:0]  max_cost;

  logic [bbms_pkg::FIELD_W-1:0] r_top, r_left, r_bot, r_rgt;
  logic [bbms_pkg::FIELD_W-1:0] c_top, c_left, c_bot, c_rgt;
  logic [bbms_pkg::AREA_W-1:0]  c_area;
  logic                         c_valid;
  logic                         c_last;

  logic [1:0]                   mul_step;
  logic                         root_sel;
  logic [bbms_pkg::SQ_W-1:0]    sum_a;
  logic [bbms_pkg::SQ_W-1:0]    sum_b;
  logic [bbms_pkg::SUM_W-1:0]   cost_sum;

  logic [bbms_pkg::COORD_W-1:0]   op_a, op_b, adiff;
  logic [2*bbms_pkg::COORD_W-1:0] sq;
  logic [bbms_pkg::RADP_W-1:0]    radicand;
  logic                           root_start;
  logic                           root_done;
  logic [bbms_pkg::ROOT_W-1:0]    root;
  logic [bbms_pkg::CMP_W-1:0]     cost_wide;
  logic                           accept;
  logic                           out_free;
  bbms_pkg::eval_t                eval;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign root_start    = (state == ST_LAUNCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_cost <= bbms_pkg::MAX_COST_RST;
    end else if (cfg_we) begin
      max_cost <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_top   <= s_axis_tdata[bbms_pkg::OFS_RTOP  +: bbms_pkg::FIELD_W];
      r_left  <= s_axis_tdata[bbms_pkg::OFS_RLEFT +: bbms_pkg::FIELD_W];
      r_bot   <= s_axis_tdata[bbms_pkg::OFS_RBOT  +: bbms_pkg::FIELD_W];
      r_rgt   <= s_axis_tdata[bbms_pkg::OFS_RRGT  +: bbms_pkg::FIELD_W];
      c_top   <= s_axis_tdata[bbms_pkg::OFS_CTOP  +: bbms_pkg::FIELD_W];
      c_left  <= s_axis_tdata[bbms_pkg::OFS_CLEFT +: bbms_pkg::FIELD_W];
      c_bot   <= s_axis_tdata[bbms_pkg::OFS_CBOT  +: bbms_pkg::FIELD_W];
      c_rgt   <= s_axis_tdata[bbms_pkg::OFS_CRGT  +: bbms_pkg::FIELD_W];
      c_area  <= s_axis_tdata[bbms_pkg::OFS_AREA  +: bbms_pkg::AREA_W];
      c_valid <= s_axis_tuser;
      c_last  <= s_axis_tlast;
    end
  end

  // shared abs-diff and squarer, one coordinate pair per step
  always_comb begin
    unique case (mul_step)
      2'd0: begin
        op_a = bbms_pkg::coord_mask(c_top);
        op_b = bbms_pkg::coord_mask(r_top);
      end
      2'd1: begin
        op_a = bbms_pkg::coord_mask(c_left);
        op_b = bbms_pkg::coord_mask(r_left);
      end
      2'd2: begin
        op_a = bbms_pkg::coord_mask(c_bot);
        op_b = bbms_pkg::coord_mask(r_bot);
      end
      2'd3: begin
        op_a = bbms_pkg::coord_mask(c_rgt);
        op_b = bbms_pkg::coord_mask(r_rgt);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    adiff = (op_a > op_b) ? (op_a - op_b) : (op_b - op_a);
    sq    = adiff * adiff;
  end

  always_comb begin
    radicand = bbms_pkg::RADP_W'({(root_sel ? sum_b : sum_a), 8'h00});
  end

  bbms_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_MUL;
      ST_MUL:    if (mul_step == 2'd3) state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = ST_ROOT;
      ST_ROOT: begin
        if (root_done) state_next = root_sel ? ST_DECIDE : ST_LAUNCH;
      end
      ST_DECIDE: if (!c_last || out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mul_step <= 2'd0;
      root_sel <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MUL) begin
        mul_step <= mul_step + 2'd1;
      end
      if (accept) begin
        root_sel <= 1'b0;
      end else if (state == ST_ROOT && root_done) begin
        root_sel <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cost_sum <= '0;
    end else if (state == ST_ROOT && root_done) begin
      cost_sum <= cost_sum + bbms_pkg::SUM_W'(root);
    end
    if (state == ST_MUL) begin
      unique case (mul_step)
        2'd0:    sum_a <= bbms_pkg::SQ_W'(sq);
        2'd1:    sum_a <= sum_a + bbms_pkg::SQ_W'(sq);
        2'd2:    sum_b <= bbms_pkg::SQ_W'(sq);
        2'd3:    sum_b <= sum_b + bbms_pkg::SQ_W'(sq);
        default: sum_a <= sum_a;
      endcase
    end
  end

  always_comb begin
    cost_wide  = bbms_pkg::CMP_W'(cost_sum);
    eval.fire  = (state == ST_DECIDE) && (!c_last || out_free);
    eval.valid = c_valid;
    eval.last  = c_last;
    eval.area  = c_area;
    eval.cost  = (cost_wide > bbms_pkg::CMP_W'(bbms_pkg::COST_MAX)) ?
                 bbms_pkg::COST_MAX : cost_wide[bbms_pkg::COST_W-1:0];
  end

  bbms_select u_select (
    .clk       (clk),
    .rst       (rst),
    .eval      (eval),
    .max_cost  (max_cost),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_found (m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ src/bbms_checker.sv @@
`default_nettype none

`include "best_box_match_select_top_macros.svh"

module bbms_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [bbms_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                            m_axis_tuser
);

  logic out_wait;

  assign out_wait = m_axis_tvalid && !m_axis_tready;

  // a held result does not change or drop
  `BBMS_ASSERT(a_out_hold, clk, rst, out_wait |=> m_axis_tvalid && $stable(m_axis_tdata))

  // busy right after taking a candidate
  `BBMS_ASSERT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // an empty run reports all-zero fields
  `BBMS_ASSERT(a_empty_zero, clk, rst, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)

  // nothing pending coming out of reset
  `BBMS_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !m_axis_tvalid)

endmodule

bind best_box_match_select_top bbms_checker u_bbms_checker (.*);

`default_nettype wire
